[hw/rtl/obrt_pkg.sv]
// Shared constants, codes and types of the opaque bounding box row extent tracer.
package obrt_pkg;

    // Frame size limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Fixed field widths of the ports.
    localparam int CFG_W    = 11;
    localparam int CFGIDX_W = 2;
    localparam int ALPHA_W  = 8;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    // Configuration register indexes.
    localparam logic [CFGIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    // Operation codes of an input item.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_POINT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FINISHED   = 2'd3;

    // One entry of the row store.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] left;
        logic [COL_W-1:0] right;
    } t_row_entry;

    // Write request into the row store at the end of a row.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        t_row_entry       data;
    } t_row_wr;

    // Frame status and bounding box handed from the pixel tracker to the readout.
    typedef struct packed {
        logic             done;
        logic             any;
        logic [COL_W-1:0] left;
        logic [COL_W-1:0] right;
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bottom;
    } t_frame_info;

endpackage

[hw/rtl/obrt_row_store.sv]
// Per-row extent memory: one write port, one registered read port.
module obrt_row_store (
    input  logic                            i_clk,
    input  obrt_pkg::t_row_wr               i_wr,
    input  logic [obrt_pkg::ROW_W-1:0]      i_rd_addr,
    output obrt_pkg::t_row_entry            o_rd_data
);
    import obrt_pkg::*;

    t_row_entry r_mem [MAX_HEIGHT];
    t_row_entry r_rd_data;

    // Write at the end of each row.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read: the data for an address appears in the next cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/obrt_pixel_track.sv]
// Raster position, per-row extents and bounding box tracking of incoming pixels.
module obrt_pixel_track (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pixel,
    input  logic [obrt_pkg::ALPHA_W-1:0]      i_alpha,
    input  logic [obrt_pkg::CFG_W-1:0]        i_width,
    input  logic [obrt_pkg::CFG_W-1:0]        i_height,
    input  logic [obrt_pkg::ALPHA_W-1:0]      i_threshold,
    output obrt_pkg::t_row_wr                 o_wr,
    output obrt_pkg::t_frame_info             o_frame
);
    import obrt_pkg::*;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_done, n_done;
    logic [COL_W-1:0] r_first, n_first;
    logic [COL_W-1:0] r_last, n_last;
    logic             r_has, n_has;
    logic [COL_W-1:0] r_left, n_left;
    logic [COL_W-1:0] r_right, n_right;
    logic [ROW_W-1:0] r_top, n_top;
    logic [ROW_W-1:0] r_bottom, n_bottom;
    logic             r_any, n_any;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [COL_W-1:0] col, first, last, left, right;
    logic [ROW_W-1:0] row, top, bottom;
    logic             has, any, opaque, row_end, frame_end;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    t_row_wr          wr;

    // Effective frame size: zero acts as one, large values saturate.
    always_comb begin
        if (i_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (i_width > CFG_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        if (i_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (i_height > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_height;
        end
    end

    // A pixel after a completed frame starts a fresh frame at the origin.
    always_comb begin
        col    = r_done ? '0 : r_col;
        row    = r_done ? '0 : r_row;
        first  = r_done ? '0 : r_first;
        last   = r_done ? '0 : r_last;
        has    = r_done ? 1'b0 : r_has;
        any    = r_done ? 1'b0 : r_any;
        left   = r_done ? '1 : r_left;
        right  = r_done ? '0 : r_right;
        top    = r_done ? '1 : r_top;
        bottom = r_done ? '0 : r_bottom;
    end

    // Pixel update: box, row extents, raster advance and row write-back.
    always_comb begin
        opaque    = i_alpha > i_threshold;
        col_inc   = {1'b0, col} + (COL_W+1)'(1);
        row_inc   = {1'b0, row} + (ROW_W+1)'(1);
        row_end   = CFG_W'(col_inc) >= w_eff;
        frame_end = row_end && (CFG_W'(row_inc) >= h_eff);

        n_left   = (opaque && col < left) ? col : left;
        n_right  = (opaque && col > right) ? col : right;
        n_top    = (opaque && row < top) ? row : top;
        n_bottom = (opaque && row > bottom) ? row : bottom;
        n_any    = any | opaque;
        n_first  = (opaque && !has) ? col : first;
        n_last   = opaque ? col : last;
        n_has    = has | opaque;

        wr.en         = i_pixel && row_end;
        wr.addr       = row;
        wr.data.valid = n_has;
        wr.data.left  = n_first;
        wr.data.right = n_last;

        n_col  = col_inc[COL_W-1:0];
        n_row  = row;
        n_done = 1'b0;
        if (row_end) begin
            n_first = '0;
            n_last  = '0;
            n_has   = 1'b0;
            n_col   = '0;
            n_row   = frame_end ? '0 : row_inc[ROW_W-1:0];
            n_done  = frame_end;
        end
    end

    // Outside reset, state registers change only on an accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_done   <= 1'b0;
            r_first  <= '0;
            r_last   <= '0;
            r_has    <= 1'b0;
            r_left   <= '1;
            r_right  <= '0;
            r_top    <= '1;
            r_bottom <= '0;
            r_any    <= 1'b0;
        end else if (i_pixel) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_done   <= n_done;
            r_first  <= n_first;
            r_last   <= n_last;
            r_has    <= n_has;
            r_left   <= n_left;
            r_right  <= n_right;
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_any    <= n_any;
        end
    end

    assign o_wr           = wr;
    assign o_frame.done   = r_done;
    assign o_frame.any    = r_any;
    assign o_frame.left   = r_left;
    assign o_frame.right  = r_right;
    assign o_frame.top    = r_top;
    assign o_frame.bottom = r_bottom;

endmodule

[hw/rtl/obrt_readout.sv]
// Contour readout: scans the row store down for left extents, then up for right extents.
module obrt_readout (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_read,
    input  logic                              i_clear,
    input  obrt_pkg::t_frame_info             i_frame,
    input  obrt_pkg::t_row_entry              i_rd_data,
    output logic [obrt_pkg::ROW_W-1:0]        o_rd_addr,
    output logic                              o_busy,
    output logic                              o_result_valid,
    output logic [obrt_pkg::STATUS_W-1:0]     o_status,
    output logic [obrt_pkg::POS_W-1:0]        o_point_x,
    output logic [obrt_pkg::POS_W-1:0]        o_point_y,
    output logic                              o_last_point,
    output logic [obrt_pkg::POS_W-1:0]        o_box_left,
    output logic [obrt_pkg::POS_W-1:0]        o_box_right,
    output logic [obrt_pkg::POS_W-1:0]        o_box_top,
    output logic [obrt_pkg::POS_W-1:0]        o_box_bottom
);
    import obrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_scan_state;

    typedef enum logic [3:0] {
        P_FRESH = 4'b0001,
        P_DOWN  = 4'b0010,
        P_UP    = 4'b0100,
        P_END   = 4'b1000
    } t_phase;

    t_scan_state      r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [POS_W-1:0] r_x, n_x;
    logic [POS_W-1:0] r_y, n_y;
    logic             r_last, n_last;
    logic [POS_W-1:0] r_bl, n_bl;
    logic [POS_W-1:0] r_br, n_br;
    logic [POS_W-1:0] r_bt, n_bt;
    logic [POS_W-1:0] r_bb, n_bb;
    logic [ROW_W-1:0] rd_addr;
    logic [ROW_W-1:0] start_row;
    logic [ROW_W-1:0] step_row;

    // Read handling and the row scan, one stored row examined per cycle.
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_row     = r_row;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_x       = r_x;
        n_y       = r_y;
        n_last    = r_last;
        n_bl      = r_bl;
        n_br      = r_br;
        n_bt      = r_bt;
        n_bb      = r_bb;
        rd_addr   = r_row;
        start_row = (r_phase == P_FRESH) ? i_frame.top : r_row;
        step_row  = (r_phase == P_UP) ? r_row - ROW_W'(1) : r_row + ROW_W'(1);

        case (r_state)
            S_IDLE: begin
                if (i_read) begin
                    if (!i_frame.done || !i_frame.any || r_phase == P_END) begin
                        n_strobe = 1'b1;
                        n_x      = '0;
                        n_y      = '0;
                        n_last   = 1'b0;
                        n_bl     = '0;
                        n_br     = '0;
                        n_bt     = '0;
                        n_bb     = '0;
                        if (!i_frame.done) begin
                            n_status = ST_INCOMPLETE;
                        end else if (!i_frame.any) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status = ST_FINISHED;
                            n_bl     = POS_W'(i_frame.left);
                            n_br     = POS_W'(i_frame.right);
                            n_bt     = POS_W'(i_frame.top);
                            n_bb     = POS_W'(i_frame.bottom);
                        end
                    end else begin
                        rd_addr = start_row;
                        n_row   = start_row;
                        n_state = S_SCAN;
                        if (r_phase == P_FRESH) begin
                            n_phase = P_DOWN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_rd_data.valid) begin
                    // Row holds opaque pixels: return its extent.
                    n_strobe = 1'b1;
                    n_status = ST_POINT;
                    n_x      = POS_W'((r_phase == P_UP) ? i_rd_data.right : i_rd_data.left);
                    n_y      = POS_W'(r_row);
                    n_last   = (r_phase == P_UP) && (r_row == i_frame.top);
                    n_bl     = POS_W'(i_frame.left);
                    n_br     = POS_W'(i_frame.right);
                    n_bt     = POS_W'(i_frame.top);
                    n_bb     = POS_W'(i_frame.bottom);
                    n_state  = S_IDLE;
                    if (r_phase == P_UP) begin
                        if (r_row == i_frame.top) begin
                            n_phase = P_END;
                        end else begin
                            n_row = step_row;
                        end
                    end else begin
                        if (r_row == i_frame.bottom) begin
                            n_phase = P_UP;
                        end else begin
                            n_row = step_row;
                        end
                    end
                end else begin
                    // Empty row: move on and read the next one.
                    n_row   = step_row;
                    rd_addr = step_row;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Any pixel restarts the readout of the frame.
        if (i_clear) begin
            n_phase = P_FRESH;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= P_FRESH;
            r_row    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_row    <= n_row;
            r_strobe <= n_strobe;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_x      <= n_x;
        r_y      <= n_y;
        r_last   <= n_last;
        r_bl     <= n_bl;
        r_br     <= n_br;
        r_bt     <= n_bt;
        r_bb     <= n_bb;
    end

    assign o_rd_addr      = rd_addr;
    assign o_busy         = (r_state == S_SCAN);
    assign o_result_valid = r_strobe;
    assign o_status       = r_status;
    assign o_point_x      = r_x;
    assign o_point_y      = r_y;
    assign o_last_point   = r_last;
    assign o_box_left     = r_bl;
    assign o_box_right    = r_br;
    assign o_box_top      = r_bt;
    assign o_box_bottom   = r_bb;

endmodule

[hw/rtl/opaque_bbox_row_extent_tracer_top.sv]
// Pixel samples give no result; busy stays low for them.
// A read that returns no point gives its result in the cycle after the transfer.
// A read that returns a point reads the row store, scans past any empty rows and then
// registers the point; the row store read port examines one row per cycle.
// Reset is synchronous and active low; it clears the raster position, box and readout,
// not the row store. The result receiver cannot stall; each result shows for one cycle.
module opaque_bbox_row_extent_tracer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [obrt_pkg::ALPHA_W-1:0]      i_alpha,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [obrt_pkg::CFGIDX_W-1:0]     i_cfg_index,
    input  logic [obrt_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_result_valid,
    output logic [obrt_pkg::STATUS_W-1:0]     o_status,
    output logic [obrt_pkg::POS_W-1:0]        o_point_x,
    output logic [obrt_pkg::POS_W-1:0]        o_point_y,
    output logic                              o_last_point,
    output logic [obrt_pkg::POS_W-1:0]        o_box_left,
    output logic [obrt_pkg::POS_W-1:0]        o_box_right,
    output logic [obrt_pkg::POS_W-1:0]        o_box_top,
    output logic [obrt_pkg::POS_W-1:0]        o_box_bottom
);
    import obrt_pkg::*;

    logic [CFG_W-1:0]   r_image_width;
    logic [CFG_W-1:0]   r_image_height;
    logic [ALPHA_W-1:0] r_threshold;

    logic        accept;
    logic        pixel;
    logic        read;
    t_row_wr     row_wr;
    t_frame_info frame;
    t_row_entry  rd_data;
    logic [ROW_W-1:0] rd_addr;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign pixel       = accept && (i_operation == OP_PIXEL);
    assign read        = accept && (i_operation == OP_READ);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(MAX_WIDTH);
            r_image_height <= CFG_W'(MAX_HEIGHT);
            r_threshold    <= ALPHA_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    obrt_pixel_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (pixel),
        .i_alpha     (i_alpha),
        .i_width     (r_image_width),
        .i_height    (r_image_height),
        .i_threshold (r_threshold),
        .o_wr        (row_wr),
        .o_frame     (frame)
    );

    obrt_row_store u_store (
        .i_clk     (i_clk),
        .i_wr      (row_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    obrt_readout u_readout (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_read         (read),
        .i_clear        (pixel),
        .i_frame        (frame),
        .i_rd_data      (rd_data),
        .o_rd_addr      (rd_addr),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_point   (o_last_point),
        .o_box_left     (o_box_left),
        .o_box_right    (o_box_right),
        .o_box_top      (o_box_top),
        .o_box_bottom   (o_box_bottom)
    );

`ifndef SYNTHESIS
    // A result is never shown while a scan is still running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe during a row scan");

    // Every accepted read either answers at once or starts a scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read |=> (o_result_valid || busy))
        else $error("read transfer produced neither result nor scan");

    // Scans only run over a completed frame that holds opaque pixels.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (frame.done && frame.any))
        else $error("row scan without a completed non-empty frame");

    // A returned point lies within the bounding box rows.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_POINT) |->
            (o_point_y >= o_box_top && o_point_y <= o_box_bottom))
        else $error("contour point outside the bounding box rows");
`endif

endmodule

[tb/sv/opaque_bbox_row_extent_tracer_top_tb.sv]
// Self-checking testbench for the opaque bounding box and row extent tracer.
`timescale 1ns / 1ps

module opaque_bbox_row_extent_tracer_top_tb;
    import obrt_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 25;
    localparam int WIDE_PIXELS   = 100;
    localparam int TALL_ROWS     = 150;

    // One result of a read, laid out field by field as on the ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic                last;
        logic [POS_W-1:0]    left;
        logic [POS_W-1:0]    right;
        logic [POS_W-1:0]    top;
        logic [POS_W-1:0]    bottom;
    } t_contour_result;

    // Tracks the frame the block sees and holds the results its reads must return.
    class contour_scoreboard;
        logic [CFG_W-1:0]   width_reg;
        logic [CFG_W-1:0]   height_reg;
        logic [ALPHA_W-1:0] alpha_limit;
        int unsigned        col_pos;
        int unsigned        row_pos;
        bit                 frame_complete;
        int unsigned        run_first;
        int unsigned        run_last;
        bit                 run_hit;
        bit [POS_W-1:0]     left_edge [MAX_HEIGHT];
        bit [POS_W-1:0]     right_edge [MAX_HEIGHT];
        bit                 row_hit [MAX_HEIGHT];
        int unsigned        box_l;
        int unsigned        box_r;
        int unsigned        box_t;
        int unsigned        box_b;
        bit                 frame_hit;
        int unsigned        points_sent;
        t_contour_result    expected_points [$];
        int                 errors;
        int                 results_checked;
        int                 points_checked;
        int                 frames_traced;

        function new();
            width_reg   = CFG_W'(MAX_WIDTH);
            height_reg  = CFG_W'(MAX_HEIGHT);
            alpha_limit = 8'd2;
            restart_frame();
        endfunction

        // Zero acts as one, anything above the maximum acts as the maximum.
        function int unsigned effective_size(int unsigned v, int unsigned limit);
            if (v == 0) return 1;
            return (v > limit) ? limit : v;
        endfunction

        function void restart_frame();
            col_pos        = 0;
            row_pos        = 0;
            frame_complete = 1'b0;
            run_first      = 0;
            run_last       = 0;
            run_hit        = 1'b0;
            box_l          = 1023;
            box_r          = 0;
            box_t          = 1023;
            box_b          = 0;
            frame_hit      = 1'b0;
            points_sent    = 0;
        endfunction

        function void write_register(logic [CFGIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg = val;
                CFG_IMAGE_HEIGHT: height_reg = val;
                CFG_THRESHOLD:    alpha_limit = val[ALPHA_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the raster by one pixel and folds it into the box and row extents.
        function void trace_pixel(logic [ALPHA_W-1:0] a);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            w = effective_size(width_reg, MAX_WIDTH);
            h = effective_size(height_reg, MAX_HEIGHT);
            if (frame_complete) restart_frame();
            c = col_pos;
            r = row_pos;
            if (a > alpha_limit) begin
                if (!frame_hit) begin
                    box_l     = c;
                    box_r     = c;
                    box_t     = r;
                    box_b     = r;
                    frame_hit = 1'b1;
                end else begin
                    if (c < box_l) box_l = c;
                    if (c > box_r) box_r = c;
                    if (r < box_t) box_t = r;
                    if (r > box_b) box_b = r;
                end
                if (!run_hit) run_first = c;
                run_last = c;
                run_hit  = 1'b1;
            end
            c++;
            // End of row: store its extents and move to the next one.
            if (c >= w) begin
                if (r < MAX_HEIGHT) begin
                    left_edge[r]  = POS_W'(run_first);
                    right_edge[r] = POS_W'(run_last);
                    row_hit[r]    = run_hit;
                end
                run_hit   = 1'b0;
                run_first = 0;
                run_last  = 0;
                c = 0;
                r++;
                if (r >= h) begin
                    r = 0;
                    frame_complete = 1'b1;
                    points_sent    = 0;
                    frames_traced++;
                end
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function int unsigned rows_in_box();
            int unsigned r;
            int unsigned n;
            n = 0;
            for (r = box_t; r <= box_b && r < MAX_HEIGHT; r++)
                if (row_hit[r]) n++;
            return n;
        endfunction

        // Row number of the k-th contributing row, counted from the top of the box.
        function int unsigned valid_row_at(int unsigned k);
            int unsigned r;
            int unsigned seen;
            seen = 0;
            for (r = box_t; r <= box_b && r < MAX_HEIGHT; r++) begin
                if (row_hit[r]) begin
                    if (seen == k) return r;
                    seen++;
                end
            end
            return box_t;
        endfunction

        // Left extents go top down, then right extents bottom up.
        function t_contour_result contour_point();
            t_contour_result res;
            int unsigned     n;
            int unsigned     sel;
            res = '0;
            if (!frame_complete) begin
                res.status = ST_INCOMPLETE;
                return res;
            end
            if (!frame_hit) begin
                res.status = ST_EMPTY;
                return res;
            end
            res.left   = POS_W'(box_l);
            res.right  = POS_W'(box_r);
            res.top    = POS_W'(box_t);
            res.bottom = POS_W'(box_b);
            n = rows_in_box();
            if (points_sent >= 2 * n) begin
                res.status = ST_FINISHED;
                return res;
            end
            if (points_sent < n) begin
                sel   = valid_row_at(points_sent);
                res.x = left_edge[sel];
            end else begin
                sel   = valid_row_at(2 * n - 1 - points_sent);
                res.x = right_edge[sel];
            end
            res.status = ST_POINT;
            res.y      = POS_W'(sel);
            res.last   = (points_sent == 2 * n - 1);
            points_sent++;
            return res;
        endfunction

        // Pixels still needed before the current frame is complete.
        function int unsigned pixels_left();
            int unsigned w;
            int unsigned h;
            int unsigned rest;
            w = effective_size(width_reg, MAX_WIDTH);
            h = effective_size(height_reg, MAX_HEIGHT);
            if (frame_complete) return w * h;
            rest = (col_pos >= w) ? 1 : w - col_pos;
            if (row_pos + 1 < h) rest += (h - row_pos - 1) * w;
            return rest;
        endfunction

        function int unsigned points_left();
            int unsigned n;
            if (!frame_complete || !frame_hit) return 0;
            n = rows_in_box();
            return (2 * n > points_sent) ? 2 * n - points_sent : 0;
        endfunction

        function void note_item(logic op, logic [ALPHA_W-1:0] a);
            if (op == OP_PIXEL) trace_pixel(a);
            else expected_points.push_back(contour_point());
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_contour_result got);
            t_contour_result want;
            if (expected_points.size() == 0) begin
                $display("%0t: result with no read outstanding, actual status %0d",
                         $time, got.status);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            results_checked++;
            if (want.status == ST_POINT) points_checked++;
            compare_field("status", want.status, got.status);
            compare_field("point_x", want.x, got.x);
            compare_field("point_y", want.y, got.y);
            compare_field("last_point", want.last, got.last);
            compare_field("box_left", want.left, got.left);
            compare_field("box_right", want.right, got.right);
            compare_field("box_top", want.top, got.top);
            compare_field("box_bottom", want.bottom, got.bottom);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_operation = OP_PIXEL;
    logic [ALPHA_W-1:0]  i_alpha = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFGIDX_W-1:0] i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic [POS_W-1:0]    o_point_x;
    logic [POS_W-1:0]    o_point_y;
    logic                o_last_point;
    logic [POS_W-1:0]    o_box_left;
    logic [POS_W-1:0]    o_box_right;
    logic [POS_W-1:0]    o_box_top;
    logic [POS_W-1:0]    o_box_bottom;

    contour_scoreboard sb;
    int idle_pct = 0;
    int items_sent = 0;
    int cfg_writes = 0;
    int idle_plan [4] = '{0, 77, 0, 28};

    opaque_bbox_row_extent_tracer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_alpha        (i_alpha),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_point   (o_last_point),
        .o_box_left     (o_box_left),
        .o_box_right    (o_box_right),
        .o_box_top      (o_box_top),
        .o_box_bottom   (o_box_bottom)
    );

    always #5 i_clk = ~i_clk;

    // Every strobed result is compared against the oldest outstanding read.
    always @(posedge i_clk) begin : result_monitor
        t_contour_result got;
        if (i_rst_n && o_result_valid) begin
            got.status = o_status;
            got.x      = o_point_x;
            got.y      = o_point_y;
            got.last   = o_last_point;
            got.left   = o_box_left;
            got.right  = o_box_right;
            got.top    = o_box_top;
            got.bottom = o_box_bottom;
            sb.check_result(got);
        end
    end

    // Presents one item, with random idle cycles ahead of it, and waits for its transfer.
    task automatic send_item(input logic op, input logic [ALPHA_W-1:0] a);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_alpha     <= a;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(op, a);
        items_sent++;
    endtask

    task automatic read_points(input int n);
        repeat (n) send_item(OP_READ, ALPHA_W'($urandom));
    endtask

    // Lets every outstanding read return and the pixel pipeline drain.
    task automatic settle();
        start <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_register(idx, val);
        cfg_writes++;
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [ALPHA_W-1:0] thr);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_THRESHOLD, CFG_W'(thr));
        i_cfg_valid <= 1'b0;
    endtask

    // Opaque with the given percentage, with values right at the threshold now and then.
    function automatic logic [ALPHA_W-1:0] pick_alpha(input int unsigned density);
        int unsigned thr;
        thr = sb.alpha_limit;
        if (thr < 255 && $urandom_range(99) < density) begin
            if ($urandom_range(3) == 0) return ALPHA_W'(thr + 1);
            return ALPHA_W'($urandom_range(255, thr + 1));
        end
        if ($urandom_range(3) == 0) return ALPHA_W'(thr);
        return ALPHA_W'($urandom_range(thr, 0));
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        if ($urandom_range(9) == 0) return '0;
        return CFG_W'($urandom_range(8, 1));
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_threshold();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return ALPHA_W'($urandom_range(8));
            default: return ALPHA_W'($urandom_range(254));
        endcase
    endfunction

    // Random content up to the end of the current frame, then its readout, with some noise.
    task automatic random_frame();
        int unsigned density;
        int unsigned reads;
        density = ($urandom_range(7) == 0) ? 0 : $urandom_range(95, 5);
        repeat (sb.pixels_left()) begin
            if ($urandom_range(39) == 0) send_item(OP_READ, ALPHA_W'($urandom));
            send_item(OP_PIXEL, pick_alpha(density));
        end
        reads = sb.points_left() + $urandom_range(2);
        // Sometimes the readout is cut short and the next frame starts over it.
        if ($urandom_range(6) == 0) reads = $urandom_range(reads);
        read_points(reads);
    endtask

    initial begin
        int pos;
        int phase;
        int phase_start;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reads before any frame, and a frame whose size changes part way through.
        send_item(OP_READ, 8'hA5);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_READ, 8'h00);
        settle();
        configure(11'd2, 11'd0, 8'd2);
        send_item(OP_PIXEL, 8'd3);
        read_points(4);

        // Nothing exceeds the top threshold, so the frame is empty.
        settle();
        configure(11'd3, 11'd2, 8'd255);
        repeat (6) send_item(OP_PIXEL, 8'hFF);
        read_points(2);

        // One contributing row between empty rows, then a new frame during readout.
        settle();
        configure(11'd0, 11'd3, 8'd0);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd1);
        send_item(OP_PIXEL, 8'd0);
        read_points(1);
        send_item(OP_PIXEL, 8'd128);
        read_points(1);
        send_item(OP_PIXEL, 8'd0);
        send_item(OP_PIXEL, 8'd0);
        read_points(3);

        // Width register above its maximum, then narrowed below the column mid-row.
        settle();
        configure(11'd2047, 11'd1, 8'd100);
        for (pos = 0; pos < WIDE_PIXELS; pos++) begin
            if (pos == 0 || pos == 57 || pos == WIDE_PIXELS - 1)
                send_item(OP_PIXEL, ALPHA_W'($urandom_range(255, 101)));
            else
                send_item(OP_PIXEL, ALPHA_W'($urandom_range(100)));
        end
        read_points(1);
        settle();
        configure(11'd50, 11'd1, 8'd100);
        send_item(OP_PIXEL, ALPHA_W'($urandom_range(255, 101)));
        read_points(3);

        // Tall frame, one column wide, with long runs of empty rows to skip.
        settle();
        configure(11'd0, CFG_W'(TALL_ROWS), 8'd100);
        for (pos = 0; pos < TALL_ROWS; pos++) begin
            if (pos == 0 || pos == 75 || pos == TALL_ROWS - 1)
                send_item(OP_PIXEL, ALPHA_W'($urandom_range(255, 101)));
            else
                send_item(OP_PIXEL, ALPHA_W'($urandom_range(100)));
        end
        read_points(7);

        // Random phases, each with its own settings and sender idle rate.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            configure(pick_size(), pick_size(), pick_threshold());
            idle_pct = idle_plan[phase % 4];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_frame();
            // Sometimes leave a frame unfinished so the next settings take effect mid-frame.
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(3, 1)) send_item(OP_PIXEL, pick_alpha(50));
        end

        settle();
        $display("Sent %0d items over %0d frames and %0d register writes.",
                 items_sent, sb.frames_traced, cfg_writes);
        $display("Checked %0d read results, %0d of them contour points.",
                 sb.results_checked, sb.points_checked);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guards against a hang anywhere in the run.
    initial begin
        #5_000_000;
        $display("Run timed out at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/obrt_pkg.sv
hw/rtl/obrt_row_store.sv
hw/rtl/obrt_pixel_track.sv
hw/rtl/obrt_readout.sv
hw/rtl/opaque_bbox_row_extent_tracer_top.sv
tb/sv/opaque_bbox_row_extent_tracer_top_tb.sv
